// ===== src/pplh_pkg.sv =====
// shared types, constants and functions of the peak pair landmark hasher
package pplh_pkg;

   localparam int FAN_OUT_DEFAULT = 15;
   localparam int FREQ_W          = 12;
   localparam int TIME_W          = 16;
   localparam int DELTA_W         = 16;
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 16;
   localparam int MSG_BYTES       = 24;
   localparam int LEN_W           = 5;
   localparam int DIGIT_CNT_W     = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DELTA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_DELTA = 1'b1;
   localparam logic [DELTA_W-1:0]     MAX_DELTA_RESET = 16'd200;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FMT,
      ST_HASH,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_peak;
      logic clear_idx;
      logic next_idx;
      logic fmt_start;
      logic hash_start;
      logic out_load;
      logic out_last;
      logic push_window;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic idx_valid;
      logic pair_ok;
      logic more_pairs;
      logic fmt_done;
      logic hash_done;
      logic out_free;
   } status_type;

   function automatic logic [31:0] sha_k(input logic [6:0] round);
      logic [31:0] k;
      if (round < 7'd20)      k = 32'h5A827999;
      else if (round < 7'd40) k = 32'h6ED9EBA1;
      else if (round < 7'd60) k = 32'h8F1BBCDC;
      else                    k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] sha_f(input logic [6:0] round,
                                         input logic [31:0] b,
                                         input logic [31:0] c,
                                         input logic [31:0] d);
      logic [31:0] f;
      if (round < 7'd20)      f = (b & c) | (~b & d);
      else if (round < 7'd40) f = b ^ c ^ d;
      else if (round < 7'd60) f = (b & c) | (b & d) | (c & d);
      else                    f = b ^ c ^ d;
      return f;
   endfunction

endpackage

// ===== src/pplh_if.sv =====
// valid/ready channel interfaces for peaks, hashes and register writes
interface pplh_req_if import pplh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FREQ_W-1:0] peak_freq;
   logic [TIME_W-1:0] peak_time;
   modport source (output valid, peak_freq, peak_time, input ready);
   modport sink   (input valid, peak_freq, peak_time, output ready);
endinterface

interface pplh_rsp_if import pplh_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [63:0]       hash_upper;
   logic [15:0]       hash_lower;
   logic [TIME_W-1:0] anchor_time;
   logic              last_of_run;
   modport source (output valid, hash_upper, hash_lower, anchor_time, last_of_run,
                   input ready);
   modport sink   (input valid, hash_upper, hash_lower, anchor_time, last_of_run,
                   output ready);
endinterface

interface pplh_csr_if import pplh_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/peak_pair_landmark_hasher_unit.sv =====
// top level: peak pair landmark hasher with sha-1 pair digests
// per pair: a scan step, the decimal text, the sha-1 rounds and the output load, plus a
//   scan step for each stored peak scanned that forms no pair, plus the accept and
//   window update steps
// throughput: one peak at a time, set by the single iterative sha-1 round unit
// reset: synchronous, active high; window empty, min delta 0, max delta 200
module peak_pair_landmark_hasher_unit
   import pplh_pkg::*;
#(
   parameter int FAN_OUT = FAN_OUT_DEFAULT
)(
   input logic clock,
   input logic reset,
   pplh_req_if.sink   req,
   pplh_rsp_if.source rsp,
   pplh_csr_if.sink   csr
);

   cmd_type    cmd;
   status_type status;
   logic [DELTA_W-1:0] min_delta_ff, max_delta_ff;

   // register writes are always taken
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_delta_ff <= '0;
         max_delta_ff <= MAX_DELTA_RESET;
      end else if (csr.valid) begin
         case (csr.index)
            CSR_MIN_DELTA: min_delta_ff <= csr.data;
            CSR_MAX_DELTA: max_delta_ff <= csr.data;
            default: ;
         endcase
      end
   end

   pplh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req.valid && req.ready),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   pplh_datapath #(.FAN_OUT(FAN_OUT)) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .peak_freq       (req.peak_freq),
      .peak_time       (req.peak_time),
      .min_delta       (min_delta_ff),
      .max_delta       (max_delta_ff),
      .out_take        (rsp.ready),
      .out_valid       (rsp.valid),
      .out_hash_upper  (rsp.hash_upper),
      .out_hash_lower  (rsp.hash_lower),
      .out_anchor_time (rsp.anchor_time),
      .out_last        (rsp.last_of_run)
   );

endmodule

// ===== src/pplh_sha1.sv =====
// iterative sha-1 core: one block of up to 23 message bytes, one round a cycle
module pplh_sha1
   import pplh_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MSG_BYTES*8-1:0]  msg,
   input  logic [LEN_W-1:0]        msg_len,
   output logic                    done,
   output logic [79:0]             digest
);

   logic [31:0]  w_ff [16];
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]   round_ff;
   logic         busy_ff;
   logic         done_ff;
   logic [511:0] blk;
   logic [31:0]  w_cur, w_new, t;

   // padded block: message bytes, 0x80, zeros, 64-bit bit length
   always_comb begin
      blk = '0;
      for (int i = 0; i < MSG_BYTES; i++) begin
         if (5'(i) < msg_len) blk[511-8*i -: 8] = msg[MSG_BYTES*8-1-8*i -: 8];
         else if (5'(i) == msg_len) blk[511-8*i -: 8] = 8'h80;
      end
      blk[15:0] = {8'd0, msg_len, 3'd0};
   end

   assign w_cur = w_ff[0];
   assign w_new = {w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0]};
   assign t = {a_ff[26:0], a_ff[31:27]} + sha_f(round_ff, b_ff, c_ff, d_ff) + e_ff
              + sha_k(round_ff) + w_cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
         end else if (busy_ff) begin
            round_ff <= round_ff + 7'd1;
            if (round_ff == 7'd79) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= blk[511-32*i -: 32];
         a_ff <= 32'h67452301;
         b_ff <= 32'hEFCDAB89;
         c_ff <= 32'h98BADCFE;
         d_ff <= 32'h10325476;
         e_ff <= 32'hC3D2E1F0;
      end else if (busy_ff) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= {w_new[30:0], w_new[31]};
         e_ff <= d_ff;
         d_ff <= c_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff;
         a_ff <= t;
      end
   end

   assign done = done_ff;
   assign digest = {a_ff + 32'h67452301, b_ff + 32'hEFCDAB89,
                    16'((c_ff + 32'h98BADCFE) >> 16)};

endmodule

// ===== src/pplh_datapath.sv =====
// window, pair test, decimal text builder, hash core and output register
module pplh_datapath
   import pplh_pkg::*;
#(
   parameter int FAN_OUT = FAN_OUT_DEFAULT
)(
   input  logic                clock,
   input  logic                reset,
   input  cmd_type             cmd,
   output status_type          status,
   input  logic [FREQ_W-1:0]   peak_freq,
   input  logic [TIME_W-1:0]   peak_time,
   input  logic [DELTA_W-1:0]  min_delta,
   input  logic [DELTA_W-1:0]  max_delta,
   input  logic                out_take,
   output logic                out_valid,
   output logic [63:0]         out_hash_upper,
   output logic [15:0]         out_hash_lower,
   output logic [TIME_W-1:0]   out_anchor_time,
   output logic                out_last
);

   localparam int DEPTH = FAN_OUT - 1;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [FREQ_W-1:0] win_freq_ff [DEPTH];
   logic [TIME_W-1:0] win_time_ff [DEPTH];
   logic [CNT_W-1:0]  fill_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic [FREQ_W-1:0] f2_ff;
   logic [TIME_W-1:0] t2_ff;
   logic [FREQ_W-1:0] f1;
   logic [TIME_W-1:0] t1;
   logic [TIME_W-1:0] dt;
   logic              ok;

   // text builder: three numbers, least digit first, shifted in from the right
   logic [MSG_BYTES*8-1:0] msg_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [1:0]             field_ff;
   logic [DELTA_W-1:0]     val_ff;
   logic [7:0]             digits_ff [5];
   logic [DIGIT_CNT_W-1:0] ndig_ff;
   logic                   fmt_busy_ff;
   logic                   emit_ff;
   logic                   fmt_done_ff;
   logic [DELTA_W-1:0]     quot;
   logic [3:0]             rem;
   logic [31:0]            prod;

   logic        h_done;
   logic [79:0] h_digest;
   logic        out_valid_ff;
   logic [63:0] out_hu_ff;
   logic [15:0] out_hl_ff;
   logic [TIME_W-1:0] out_at_ff;
   logic        out_last_ff;
   logic [TIME_W-1:0] anchor_ff;

   assign f1 = win_freq_ff[idx_ff[IDX_W-1:0]];
   assign t1 = win_time_ff[idx_ff[IDX_W-1:0]];
   assign dt = t2_ff - t1;
   assign ok = (t2_ff >= t1) && (dt >= min_delta) && (dt <= max_delta);

   // divide by ten: multiply by reciprocal, exact for 16-bit values
   assign prod = 32'(val_ff) * 32'd52429;
   assign quot = 16'(prod >> 19);
   assign rem  = 4'(val_ff - 16'(quot * 16'd10));

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (cmd.push_window) begin
         if (fill_ff < CNT_W'(DEPTH)) fill_ff <= fill_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push_window) begin
         if (fill_ff < CNT_W'(DEPTH)) begin
            win_freq_ff[fill_ff[IDX_W-1:0]] <= f2_ff;
            win_time_ff[fill_ff[IDX_W-1:0]] <= t2_ff;
         end else begin
            for (int i = 0; i < DEPTH - 1; i++) begin
               win_freq_ff[i] <= win_freq_ff[i+1];
               win_time_ff[i] <= win_time_ff[i+1];
            end
            win_freq_ff[DEPTH-1] <= f2_ff;
            win_time_ff[DEPTH-1] <= t2_ff;
         end
      end
      if (cmd.load_peak) begin
         f2_ff <= peak_freq;
         t2_ff <= peak_time;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) idx_ff <= '0;
      else if (cmd.clear_idx) idx_ff <= '0;
      else if (cmd.next_idx) idx_ff <= idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_busy_ff <= 1'b0;
         fmt_done_ff <= 1'b0;
         emit_ff     <= 1'b0;
      end else begin
         fmt_done_ff <= 1'b0;
         if (cmd.fmt_start) begin
            fmt_busy_ff <= 1'b1;
            emit_ff     <= 1'b0;
            field_ff    <= 2'd0;
            val_ff      <= DELTA_W'(f1);
            ndig_ff     <= '0;
            len_ff      <= '0;
            msg_ff      <= '0;
            anchor_ff   <= t1;
         end else if (fmt_busy_ff && !emit_ff) begin
            digits_ff[ndig_ff] <= 8'h30 + 8'(rem);
            ndig_ff <= ndig_ff + 1'b1;
            val_ff  <= quot;
            if (quot == '0) emit_ff <= 1'b1;
         end else if (fmt_busy_ff) begin
            if (ndig_ff != '0) begin
               msg_ff  <= {msg_ff[MSG_BYTES*8-9:0], digits_ff[ndig_ff - 1'b1]};
               len_ff  <= len_ff + 1'b1;
               ndig_ff <= ndig_ff - 1'b1;
            end else if (field_ff == 2'd2) begin
               fmt_busy_ff <= 1'b0;
               fmt_done_ff <= 1'b1;
            end else begin
               msg_ff   <= {msg_ff[MSG_BYTES*8-9:0], 8'h7C};
               len_ff   <= len_ff + 1'b1;
               field_ff <= field_ff + 1'b1;
               val_ff   <= (field_ff == 2'd0) ? DELTA_W'(f2_ff) : dt;
               emit_ff  <= 1'b0;
            end
         end
      end
   end

   // message left-aligned for the core
   pplh_sha1 u_sha1 (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.hash_start),
      .msg     (msg_ff << (8 * (MSG_BYTES - int'(len_ff)))),
      .msg_len (len_ff),
      .done    (h_done),
      .digest  (h_digest)
   );

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (cmd.out_load) out_valid_ff <= 1'b1;
      else if (out_take) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_hu_ff   <= h_digest[79:16];
         out_hl_ff   <= h_digest[15:0];
         out_at_ff   <= anchor_ff;
         out_last_ff <= cmd.out_last;
      end
   end

   // is any later stored peak also a pair
   logic more;
   always_comb begin
      more = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         if (CNT_W'(i) > idx_ff && CNT_W'(i) < fill_ff &&
             t2_ff >= win_time_ff[i] &&
             (t2_ff - win_time_ff[i]) >= min_delta &&
             (t2_ff - win_time_ff[i]) <= max_delta) more = 1'b1;
      end
   end

   assign status.idx_valid  = idx_ff < fill_ff;
   assign status.pair_ok    = ok;
   assign status.more_pairs = more;
   assign status.fmt_done   = fmt_done_ff;
   assign status.hash_done  = h_done;
   assign status.out_free   = !out_valid_ff || out_take;

   assign out_valid       = out_valid_ff;
   assign out_hash_upper  = out_hu_ff;
   assign out_hash_lower  = out_hl_ff;
   assign out_anchor_time = out_at_ff;
   assign out_last        = out_last_ff;

endmodule

// ===== src/pplh_ctrl.sv =====
// sequencer: scan the window, format and hash each pair, hand results out
module pplh_ctrl
   import pplh_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_fire,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      last_in   = last_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               cmd.load_peak = 1'b1;
               cmd.clear_idx = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (!status.idx_valid) begin
               cmd.push_window = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.pair_ok) begin
               cmd.fmt_start = 1'b1;
               last_in       = !status.more_pairs;
               state_in      = ST_FMT;
            end else begin
               cmd.next_idx = 1'b1;
            end
         end
         ST_FMT: begin
            if (status.fmt_done) begin
               cmd.hash_start = 1'b1;
               state_in       = ST_HASH;
            end
         end
         ST_HASH: begin
            if (status.hash_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = last_ff;
               cmd.next_idx = 1'b1;
               state_in     = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== verif/tb_top.sv =====
// testbench for the peak pair landmark hasher: sha-1 pair digests checked against a local predictor
module tb_top;
   import pplh_pkg::*;

   localparam int WIN_DEPTH  = FAN_OUT_DEFAULT - 1;
   localparam int SETTLE_CYC = 2500;   // worst-case peak, plus slack

   typedef struct packed {
      logic [63:0]       hash_upper;
      logic [15:0]       hash_lower;
      logic [TIME_W-1:0] anchor_time;
      logic              last_of_run;
   } pair_hash_type;

   logic clock;
   logic reset;

   pplh_req_if req_ch ();
   pplh_rsp_if rsp_ch ();
   pplh_csr_if csr_ch ();

   peak_pair_landmark_hasher_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source),
      .csr   (csr_ch.sink)
   );

   // predictor state: a mirror of the peak window and the delta limits
   logic [FREQ_W-1:0]  win_freq [WIN_DEPTH];
   logic [TIME_W-1:0]  win_time [WIN_DEPTH];
   int                 win_fill;
   logic [DELTA_W-1:0] min_delta;
   logic [DELTA_W-1:0] max_delta;

   pair_hash_type pending_hashes [$];
   int            mismatches;
   int            burst_left;

   // clock, period 4
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   // sha-1 of a short text (single block), first 80 digest bits
   function automatic logic [79:0] sha1_head80(input string txt);
      logic [7:0]  blk [64];
      logic [31:0] w [80];
      logic [31:0] h0, h1, h2, h3, h4;
      logic [31:0] a, b, c, d, e, f, k, t;
      logic [15:0] bits;
      int          n;
      n = txt.len();
      for (int i = 0; i < 64; i++) blk[i] = 8'h00;
      for (int i = 0; i < n; i++) blk[i] = txt[i];
      blk[n] = 8'h80;
      bits = 16'(n * 8);
      blk[62] = bits[15:8];
      blk[63] = bits[7:0];
      for (int i = 0; i < 16; i++)
         w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
      for (int i = 16; i < 80; i++)
         w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      h0 = 32'h67452301; h1 = 32'hEFCDAB89; h2 = 32'h98BADCFE;
      h3 = 32'h10325476; h4 = 32'hC3D2E1F0;
      a = h0; b = h1; c = h2; d = h3; e = h4;
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);
            k = 32'h5A827999;
         end else if (i < 40) begin
            f = b ^ c ^ d;
            k = 32'h6ED9EBA1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = 32'h8F1BBCDC;
         end else begin
            f = b ^ c ^ d;
            k = 32'hCA62C1D6;
         end
         t = rotl(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rotl(b, 30); b = a; a = t;
      end
      h0 += a; h1 += b; h2 += c;
      return {h0, h1, h2[31:16]};
   endfunction

   // expected pair hashes for one accepted peak, then the window update
   task automatic predict_pairs(input logic [FREQ_W-1:0] f2, input logic [TIME_W-1:0] t2);
      pair_hash_type run [$];
      pair_hash_type rec;
      logic [79:0] dig;
      int          dt;
      for (int i = 0; i < win_fill; i++) begin
         // a stored peak later than the new one never pairs
         if (t2 >= win_time[i]) begin
            dt = int'(t2 - win_time[i]);
            if (dt >= min_delta && dt <= max_delta) begin
               dig = sha1_head80($sformatf("%0d|%0d|%0d", win_freq[i], f2, dt));
               rec.hash_upper  = dig[79:16];
               rec.hash_lower  = dig[15:0];
               rec.anchor_time = win_time[i];
               rec.last_of_run = 1'b0;
               run = {run, rec};
            end
         end
      end
      if (run.size() > 0) run[run.size()-1].last_of_run = 1'b1;
      foreach (run[j]) pending_hashes = {pending_hashes, run[j]};
      if (win_fill < WIN_DEPTH) begin
         win_freq[win_fill] = f2;
         win_time[win_fill] = t2;
         win_fill++;
      end else begin
         for (int i = 1; i < WIN_DEPTH; i++) begin
            win_freq[i-1] = win_freq[i];
            win_time[i-1] = win_time[i];
         end
         win_freq[WIN_DEPTH-1] = f2;
         win_time[WIN_DEPTH-1] = t2;
      end
   endtask

   // send one peak item; called at a falling edge, returns at a falling edge
   task automatic send_peak(input logic [FREQ_W-1:0] f, input logic [TIME_W-1:0] t);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_ch.valid     <= 1'b1;
      req_ch.peak_freq <= f;
      req_ch.peak_time <= t;
      do @(posedge clock); while (!req_ch.ready);
      predict_pairs(f, t);
      @(negedge clock);
   endtask

   // hold off the sender until every pair hash is back and the block is idle
   task automatic drain_and_settle();
      req_ch.valid <= 1'b0;
      burst_left = 0;
      @(negedge clock);
      while (pending_hashes.size() > 0) @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [DELTA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_MIN_DELTA) min_delta = val;
      else                      max_delta = val;
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic set_deltas(input logic [DELTA_W-1:0] lo, input logic [DELTA_W-1:0] hi);
      drain_and_settle();
      write_csr(CSR_MIN_DELTA, lo);
      write_csr(CSR_MAX_DELTA, hi);
   endtask

   // default limits straight after reset, a filling window
   task automatic test_reset_defaults();
      for (int i = 0; i < 8; i++) send_peak(12'(100 + 7 * i), 16'(i / 2));
   endtask

   // field extremes, wide frequencies, time running backwards
   task automatic test_extremes();
      send_peak(12'd0, 16'd10);
      send_peak(12'd2048, 16'd10);
      send_peak(12'd4095, 16'd210);
      send_peak(12'hAAA, 16'd211);
      send_peak(12'h555, 16'd5);       // earlier than the four peaks sent before it in this task
      send_peak(12'hFFF, 16'd5);
      set_deltas(16'd0, 16'hFFFF);
      send_peak(12'd1, 16'hFFFF);      // largest gaps, to zero-time peaks
      send_peak(12'd4095, 16'hFFFF);   // zero gap
      set_deltas(16'hFFFF, 16'hFFFF);
      send_peak(12'd9, 16'hFFFF);
      set_deltas(16'd300, 16'd100);    // minimum above maximum: no pairs at all
      send_peak(12'd33, 16'hFFFF);
      send_peak(12'd34, 16'hFFFF);
   endtask

   // random runs of sorted peaks, with some backward jumps as noise
   task automatic random_run(input int count, input int max_step);
      logic [TIME_W-1:0] t;
      logic [FREQ_W-1:0] f;
      t = 16'($urandom_range(0, 16'hFFFF));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0) t = 16'($urandom_range(0, 16'hFFFF));
         else                            t = t + 16'($urandom_range(0, max_step));
         case ($urandom_range(0, 7))
            0:       f = 12'($urandom_range(2049, 4095));
            1:       f = 12'($urandom_range(0, 9));
            default: f = 12'($urandom_range(0, 2048));
         endcase
         send_peak(f, t);
      end
   endtask

   task automatic test_random();
      set_deltas(16'd0, 16'd200);
      random_run(80, 20);
      set_deltas(16'd10, 16'd60);
      random_run(60, 15);
      set_deltas(16'd0, 16'hFFFF);
      random_run(60, 3000);
      set_deltas(16'd0, 16'd0);
      random_run(30, 1);
      set_deltas(16'($urandom_range(0, 50)), 16'($urandom_range(20, 400)));
      random_run(70, 40);
   endtask

   // receiver stall pattern: modes switch at random times
   int stall_mode;
   int stall_cnt;
   always @(negedge clock) begin
      if (stall_cnt == 0) begin
         stall_cnt  <= $urandom_range(64, 512);
         stall_mode <= $urandom_range(0, 3);
      end else begin
         stall_cnt <= stall_cnt - 1;
      end
      case (stall_mode)
         0:       rsp_ch.ready <= 1'b1;
         1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
         2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ch.ready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // result checker, oldest expectation first
   always @(posedge clock) begin
      pair_hash_type got, want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got.hash_upper  = rsp_ch.hash_upper;
         got.hash_lower  = rsp_ch.hash_lower;
         got.anchor_time = rsp_ch.anchor_time;
         got.last_of_run = rsp_ch.last_of_run;
         if (pending_hashes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected item: hash %h_%h anchor %0d last %b",
                        got.hash_upper, got.hash_lower, got.anchor_time, got.last_of_run);
         end else begin
            want = pending_hashes.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp hash %h_%h anchor %0d last %b, got %h_%h %0d %b",
                           want.hash_upper, want.hash_lower, want.anchor_time,
                           want.last_of_run, got.hash_upper, got.hash_lower,
                           got.anchor_time, got.last_of_run);
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.peak_freq = '0;
      req_ch.peak_time = '0;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_MIN_DELTA;
      csr_ch.data      = '0;
      rsp_ch.ready     = 1'b1;
      stall_mode       = 0;
      stall_cnt        = 0;
      mismatches       = 0;
      burst_left       = 0;
      win_fill         = 0;
      min_delta        = '0;
      max_delta        = MAX_DELTA_RESET;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_defaults();
      test_extremes();
      test_random();

      drain_and_settle();
      if (pending_hashes.size() > 0) mismatches += pending_hashes.size();
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog, far beyond the slowest correct run
   initial begin
      #(4 * 6000000);
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/pplh_pkg.sv
src/pplh_if.sv
src/pplh_sha1.sv
src/pplh_datapath.sv
src/pplh_ctrl.sv
src/peak_pair_landmark_hasher_unit.sv
verif/tb_top.sv
